// File: sv/udf_pkg.sv
package udf_pkg;

  // Largest field width and precision; inputs above it saturate.
  localparam int unsigned MAX_FIELD = 63;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned NDIGITS = 10;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned NDIG_W  = 4;
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);

  localparam logic [FIELD_W-1:0] MAX_FIELD_C = FIELD_W'(MAX_FIELD);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'd0;

  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } udf_state_t;

endpackage

// File: sv/unsigned_decimal_formatter.sv
// Flow: an accepted word runs 32 shift-and-add-3 steps and one sizing step, then
//   its characters are loaded into the output register one at a time.
// Throughput: the BCD shift unit holds one word; a new word is taken only after
//   the last character is loaded; one character per cycle while out_ready is high.
// Reset: rst_n (synchronous, active low) returns the sequencer to idle and
//   empties the output register; payload registers are not cleared.
module unsigned_decimal_formatter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [udf_pkg::VALUE_W-1:0]   in_value,
  input  logic [udf_pkg::FIELD_W-1:0]   in_field_width,
  input  logic                          in_has_precision,
  input  logic [udf_pkg::FIELD_W-1:0]   in_min_digits,
  input  logic                          in_left_justify,
  input  logic                          in_zero_pad,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [udf_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_is_char,
  output logic                          out_last
);
  import udf_pkg::*;

  // Sequencer
  udf_state_t state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  // Conversion datapath: binary word shifts into the BCD digit register
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [NDIGITS-1:0][DIGIT_W-1:0] bcd_r, bcd_nxt;
  logic [NDIGITS-1:0][DIGIT_W-1:0] bcd_adj;

  // Item attributes held for the whole conversion
  logic [FIELD_W-1:0] width_r, width_nxt;
  logic [FIELD_W-1:0] prec_r, prec_nxt;
  logic               left_r, left_nxt;
  logic               pad_zero_r, pad_zero_nxt;

  // Layout computed in the sizing cycle
  logic [NDIG_W-1:0]  ndig_r, ndig_nxt;
  logic [FIELD_W-1:0] body_r, body_nxt;
  logic [FIELD_W-1:0] pad_r, pad_nxt;
  logic [FIELD_W-1:0] total_r, total_nxt;
  logic [FIELD_W-1:0] pos_cnt_r, pos_cnt_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_is_char_r, out_is_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic               in_fire;
  logic               out_load;
  logic [NDIG_W-1:0]  ndig_calc;
  logic [FIELD_W-1:0] body_calc;
  logic [FIELD_W-1:0] pad_calc;
  logic [FIELD_W:0]   total_sum;
  logic               in_body;
  logic [FIELD_W-1:0] digit_pos;
  logic [DIGIT_W-1:0] digit_val;
  logic [CHAR_W-1:0]  cur_char;
  logic               cur_empty;
  logic               cur_last;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  // In S_EMIT, load a character whenever the output register is free or being drained.
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_is_char   = out_is_char_r;
  assign out_last      = out_last_r;

  // Double-dabble step: add 3 to every digit of 5 or more, each digit on its own.
  always_comb begin
    for (int d = 0; d < NDIGITS; d++) begin
      bcd_adj[d] = (bcd_r[d] >= BCD_ADJ_MIN) ? (bcd_r[d] + BCD_ADJ) : bcd_r[d];
    end
  end

  // Digit count: one past the most significant nonzero BCD digit; zero for a zero value.
  always_comb begin
    ndig_calc = '0;
    for (int d = 0; d < NDIGITS; d++) begin
      if (bcd_r[d] != '0) begin
        ndig_calc = NDIG_W'(d + 1);
      end
    end
  end

  // Body is the digits widened to the precision; pad fills up to the width.
  assign body_calc = (prec_r > {2'b00, ndig_calc}) ? prec_r : {2'b00, ndig_calc};
  assign pad_calc  = (width_r > body_calc) ? (width_r - body_calc) : '0;
  assign total_sum = {1'b0, pad_calc} + {1'b0, body_calc};

  // Character at the current position. Right-justified text puts the pad first;
  // left-justified text puts the body first and trails with spaces.
  always_comb begin
    if (left_r) begin
      in_body   = (pos_cnt_r < body_r);
      digit_pos = body_r - FIELD_W'(1) - pos_cnt_r;
    end else begin
      in_body   = (pos_cnt_r >= pad_r);
      digit_pos = total_r - FIELD_W'(1) - pos_cnt_r;
    end
    digit_val = bcd_r[digit_pos[NDIG_W-1:0]];
    if (in_body) begin
      if (digit_pos < {2'b00, ndig_r}) begin
        cur_char = ASCII_ZERO + {4'b0000, digit_val};
      end else begin
        cur_char = ASCII_ZERO;
      end
    end else if (left_r) begin
      cur_char = ASCII_SPACE;
    end else begin
      cur_char = pad_zero_r ? ASCII_ZERO : ASCII_SPACE;
    end
    cur_empty = (total_r == '0);
    cur_last  = cur_empty || (pos_cnt_r == (total_r - FIELD_W'(1)));
  end

  always_comb begin
    state_nxt       = state_r;
    bit_cnt_nxt     = bit_cnt_r;
    val_nxt         = val_r;
    bcd_nxt         = bcd_r;
    width_nxt       = width_r;
    prec_nxt        = prec_r;
    left_nxt        = left_r;
    pad_zero_nxt    = pad_zero_r;
    ndig_nxt        = ndig_r;
    body_nxt        = body_r;
    pad_nxt         = pad_r;
    total_nxt       = total_r;
    pos_cnt_nxt     = pos_cnt_r;
    out_valid_nxt   = out_valid_r;
    out_char_nxt    = out_char_r;
    out_is_char_nxt = out_is_char_r;
    out_last_nxt    = out_last_r;

    // Drop the held word once taken; a new load below overrides this.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt      = in_value;
          bcd_nxt      = '0;
          bit_cnt_nxt  = '0;
          width_nxt    = (in_field_width > MAX_FIELD_C) ? MAX_FIELD_C : in_field_width;
          if (in_has_precision) begin
            prec_nxt = (in_min_digits > MAX_FIELD_C) ? MAX_FIELD_C : in_min_digits;
          end else begin
            prec_nxt = FIELD_W'(1);
          end
          left_nxt     = in_left_justify;
          pad_zero_nxt = in_zero_pad && !in_left_justify && !in_has_precision;
          state_nxt    = S_CONV;
        end
      end
      S_CONV: begin
        // Shift the next binary bit into the adjusted BCD digits.
        bcd_nxt     = {bcd_adj[NDIGITS-1][DIGIT_W-2:0], bcd_adj[NDIGITS-2:0],
                       val_r[VALUE_W-1]};
        val_nxt     = {val_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        ndig_nxt    = ndig_calc;
        body_nxt    = body_calc;
        pad_nxt     = pad_calc;
        total_nxt   = total_sum[FIELD_W-1:0];
        pos_cnt_nxt = '0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt   = 1'b1;
          out_char_nxt    = cur_empty ? ASCII_NUL : cur_char;
          out_is_char_nxt = !cur_empty;
          out_last_nxt    = cur_last;
          pos_cnt_nxt     = pos_cnt_r + FIELD_W'(1);
          if (cur_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      pos_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      pos_cnt_r   <= pos_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r         <= val_nxt;
    bcd_r         <= bcd_nxt;
    width_r       <= width_nxt;
    prec_r        <= prec_nxt;
    left_r        <= left_nxt;
    pad_zero_r    <= pad_zero_nxt;
    ndig_r        <= ndig_nxt;
    body_r        <= body_nxt;
    pad_r         <= pad_nxt;
    total_r       <= total_nxt;
    out_char_r    <= out_char_nxt;
    out_is_char_r <= out_is_char_nxt;
    out_last_r    <= out_last_nxt;
  end

  // A sequencer state is always exactly one of the one-hot codes.
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  // An accepted word always starts the digit conversion.
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_CONV) && (bit_cnt_r == '0))
    else $error("accepted word did not start conversion");

  // The final shift step hands over to the sizing cycle.
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) && (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) |=> (state_r == S_SIZE))
    else $error("conversion did not end after the last bit");

  // The character position never runs past the text length.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (total_r != '0) |-> (pos_cnt_r < total_r))
    else $error("character position beyond text length");

  // An empty-conversion result always closes the conversion.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_is_char_r |-> out_last_r)
    else $error("empty result not marked last");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

// Checks the printf %u formatter: every accepted word is expanded into the
// expected character stream, and every character that leaves the block is
// compared with the oldest pending one. Both ports idle and stall at random.
module testbench;
  import udf_pkg::*;

  // Abort limit. The slowest legal run is roughly 300 words, each at 63
  // characters with the longest receiver stalls, plus conversion and the
  // longest send gap. CYCLE_LIMIT allows a wide margin over that run.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned RANDOM_WORDS = 270;
  // Drain time after the last character: conversion latency with margin.
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_char;
    logic              last;
  } char_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [VALUE_W-1:0]   in_value;
  logic [FIELD_W-1:0]   in_field_width;
  logic                 in_has_precision;
  logic [FIELD_W-1:0]   in_min_digits;
  logic                 in_left_justify;
  logic                 in_zero_pad;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAR_W-1:0]    out_character;
  logic                 out_is_char;
  logic                 out_last;

  // Characters still owed by the block, oldest first.
  char_result_t pending_chars[$];
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  tx_calm;
  int unsigned  rx_calm;
  int unsigned  rx_stall;

  unsigned_decimal_formatter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_field_width   (in_field_width),
    .in_has_precision (in_has_precision),
    .in_min_digits    (in_min_digits),
    .in_left_justify  (in_left_justify),
    .in_zero_pad      (in_zero_pad),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_character    (out_character),
    .out_is_char      (out_is_char),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expand one word into the characters printf %u would produce.
  task automatic queue_formatted_text(input logic [VALUE_W-1:0] value,
                                      input logic [FIELD_W-1:0] width,
                                      input logic has_prec,
                                      input logic [FIELD_W-1:0] prec_in,
                                      input logic left,
                                      input logic zpad);
    logic [DIGIT_W-1:0] digit [NDIGITS];
    logic [VALUE_W-1:0] rest;
    logic [CHAR_W-1:0]  fill;
    logic [CHAR_W-1:0]  ch;
    int                 ndig;
    int                 prec;
    int                 wid;
    int                 body;
    int                 pad;
    int                 total;
    int                 pos;
    rest = value;
    ndig = 0;
    // Collect digits least significant first; zero has none.
    while (rest != '0) begin
      digit[ndig] = DIGIT_W'(rest % 10);
      rest = rest / 10;
      ndig++;
    end
    wid  = (int'(width) > int'(MAX_FIELD)) ? int'(MAX_FIELD) : int'(width);
    prec = (int'(prec_in) > int'(MAX_FIELD)) ? int'(MAX_FIELD) : int'(prec_in);
    // Without an explicit precision, at least one digit is printed.
    if (!has_prec) prec = 1;
    body  = (prec > ndig) ? prec : ndig;
    pad   = (wid > body) ? wid - body : 0;
    total = pad + body;
    if (total == 0) begin
      // Zero value at precision zero with no width prints nothing at all.
      pending_chars.push_back('{ASCII_NUL, 1'b0, 1'b1});
    end else begin
      // Zero fill only applies when neither minus flag nor precision is given.
      fill = (zpad && !left && !has_prec) ? ASCII_ZERO : ASCII_SPACE;
      for (int idx = 0; idx < total; idx++) begin
        if (!left && idx < pad) begin
          ch = fill;
        end else if (left && idx >= body) begin
          ch = ASCII_SPACE;
        end else begin
          pos = left ? body - 1 - idx : body - 1 - (idx - pad);
          ch = (pos < ndig) ? ASCII_ZERO + CHAR_W'(digit[pos]) : ASCII_ZERO;
        end
        pending_chars.push_back('{ch, 1'b1, idx == total - 1});
      end
    end
  endtask

  // Offer one word after a random gap and hold it until it is taken. Valid
  // stays high on return so a back-to-back word needs no drop.
  task automatic send_word(input logic [VALUE_W-1:0] value,
                           input logic [FIELD_W-1:0] width,
                           input logic has_prec,
                           input logic [FIELD_W-1:0] prec,
                           input logic left,
                           input logic zpad);
    int unsigned gap;
    int unsigned pick;
    gap = 0;
    if (tx_calm > 0) begin
      tx_calm--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      gap = 0;
      else if (pick < 75) gap = $urandom_range(1, 3);
      else if (pick < 85) gap = $urandom_range(4, 7);
      else if (pick < 92) gap = $urandom_range(10, 16);
      else                tx_calm = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_value         <= value;
    in_field_width   <= width;
    in_has_precision <= has_prec;
    in_min_digits    <= prec;
    in_left_justify  <= left;
    in_zero_pad      <= zpad;
    do @(posedge clk); while (!in_ready);
    queue_formatted_text(value, width, has_prec, prec, left, zpad);
  endtask

  // Drop valid and hold off until every owed character has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Field extremes and each special case of the conversion.
  task automatic test_extremes();
    send_word('0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0);          // lone "0"
    send_word('0, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0);          // empty conversion
    send_word('0, 6'd5, 1'b1, 6'd0, 1'b0, 1'b0);          // no digits, spaces only
    send_word('0, 6'd5, 1'b1, 6'd0, 1'b1, 1'b1);          // same, left-justified
    send_word('1, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0);          // all ten digits
    send_word('1, 6'd63, 1'b0, 6'd0, 1'b0, 1'b1);         // zero fill to max width
    send_word('1, 6'd63, 1'b0, 6'd0, 1'b1, 1'b0);         // space fill on the right
    send_word(32'd7, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0);       // nonzero at precision zero
    send_word(32'd123, 6'd0, 1'b1, 6'd63, 1'b0, 1'b0);    // max precision
    send_word(32'd123, 6'd63, 1'b1, 6'd63, 1'b1, 1'b1);   // max width and precision
    send_word(32'd4000000000, 6'd5, 1'b0, 6'd0, 1'b0, 1'b0); // width below digits
    send_word(32'd99, 6'd10, 1'b0, 6'd63, 1'b0, 1'b0);    // precision flag clear
    send_word(32'd1000000000, 6'd10, 1'b1, 6'd10, 1'b0, 1'b1); // exact fit
  endtask

  // Every combination of precision, minus and zero flags.
  task automatic test_flag_combos();
    logic [2:0] flags;
    for (int combo = 0; combo < 8; combo++) begin
      flags = 3'(combo);
      send_word(32'd42, 6'd9, flags[2], 6'd5, flags[1], flags[0]);
    end
  endtask

  // Random words, mostly short fields, with decimal boundaries mixed in.
  task automatic test_random();
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] decade;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] prec;
    int unsigned        pick;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          value = '0;
        end
        1: begin
          value = '1 - VALUE_W'($urandom_range(0, 3));
        end
        2: begin
          decade = 1;
          repeat ($urandom_range(0, 9)) decade = decade * 10;
          value = decade + VALUE_W'($urandom_range(0, 2)) - 1;
        end
        3, 4: begin
          value = $urandom_range(0, 999);
        end
        default: begin
          value = $urandom;
        end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 82)      width = FIELD_W'($urandom_range(0, 15));
      else if (pick < 97) width = FIELD_W'($urandom_range(16, 63));
      else                width = MAX_FIELD_C;
      pick = $urandom_range(0, 99);
      if (pick < 85) prec = FIELD_W'($urandom_range(0, 12));
      else           prec = FIELD_W'($urandom_range(13, 63));
      send_word(value, width, 1'($urandom), prec, 1'($urandom), 1'($urandom));
      // Pause halfway so the block runs fully dry once mid-stream.
      if (n == RANDOM_WORDS / 2) wait_drained();
    end
  endtask

  // Receive side: compare each taken character with the oldest pending one,
  // then pick the next ready value. Stalls are short mostly, long sometimes,
  // with calm stretches where ready stays high.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected word: char %0d is_char %0d last %0d",
                   out_character, out_is_char, out_last);
      end else begin
        if (out_character !== pending_chars[0].character ||
            out_is_char !== pending_chars[0].is_char ||
            out_last !== pending_chars[0].last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: expected char %0d is_char %0d last %0d, got %0d %0d %0d",
                     pending_chars[0].character, pending_chars[0].is_char,
                     pending_chars[0].last, out_character, out_is_char, out_last);
        end
        void'(pending_chars.pop_front());
      end
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:24]:  rx_stall = $urandom_range(1, 3);
          [25:27]: rx_stall = $urandom_range(8, 12);
          [28:30]: rx_calm  = $urandom_range(20, 60);
          default: ;
        endcase
      end
    end
  end

  // Abort on a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("unsigned_decimal_formatter verification failed");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    tx_calm        = 0;
    rx_calm        = 0;
    rx_stall       = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_value         <= '0;
    in_field_width   <= '0;
    in_has_precision <= 1'b0;
    in_min_digits    <= '0;
    in_left_justify  <= 1'b0;
    in_zero_pad      <= 1'b0;
    out_ready        <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    wait_drained();
    test_flag_combos();
    wait_drained();
    test_random();
    wait_drained();

    // Let any stray character show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0)
      $display("unsigned_decimal_formatter verification clean");
    else
      $display("unsigned_decimal_formatter verification failed");
    $finish;
  end

endmodule
